### sv/bga_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bga_pkg
// Shared types and constants of the bf16 gradient accumulator bank.
// ----------------------------------------------------------------------------
package bga_pkg;

  localparam int COMPONENTS = 9;
  localparam int SUM_W      = 64;

  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_ADD   = 3'd1;
  localparam logic [2:0] ACT_MAC   = 3'd2;
  localparam logic [2:0] ACT_LOSS  = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  localparam logic [3:0] COMP_LAST_VALUE = 4'd5;
  localparam logic [3:0] COMP_LOSS       = 4'd9;

  localparam logic [4:0] FB_VALUE   = 5'd16;
  localparam logic [4:0] FB_WEIGHT  = 5'd15;
  localparam logic [4:0] FB_FACTOR  = 5'd14;
  localparam logic [4:0] FB_PRODUCT = 5'd29;
  localparam logic [4:0] FB_LOSS    = 5'd28;

  localparam logic [7:0]  EXP_FLUSH  = 8'hE3;
  localparam logic [30:0] SAT_MAG    = 31'h4000_0000;
  localparam logic [30:0] F32_INF    = 31'h7F80_0000;
  localparam logic [4:0]  ACTIVE_RST = 5'd16;

  typedef logic [COMPONENTS-1:0][SUM_W-1:0] row_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ACC,
    OP_LOSS,
    OP_READ_SUM,
    OP_READ_LOSS,
    OP_READ_ZERO
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         slot;
    logic [3:0]         comp;
    logic [4:0]         fbits;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } entry_t;

endpackage
`default_nettype wire

### sv/bga_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bga_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/bga_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bga_queue
// Two-entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module bga_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  input  wire bga_pkg::entry_t push_data,
  output      logic            push_ready,
  output      logic            pop_valid,
  output      bga_pkg::entry_t pop_data,
  input  wire logic            pop
);

  import bga_pkg::*;

  entry_t     store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        store[wr_ptr] <= push_data;
        wr_ptr        <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/bga_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bga_front
// Takes input transfers, converts bf16 operands to fixed point, turns each
// valid action into a queue operation and holds the active_slots register.
// ----------------------------------------------------------------------------
module bga_front #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [4:0]      cfg_data,
  input  wire logic            item_valid,
  output      logic            item_ready,
  input  wire logic [2:0]      action,
  input  wire logic [3:0]      slot,
  input  wire logic [3:0]      component,
  input  wire logic [15:0]     value_a,
  input  wire logic [15:0]     value_b,
  output      logic            push_valid,
  output      bga_pkg::entry_t push_data,
  input  wire logic            push_ready
);

  import bga_pkg::*;

  logic [4:0] active_slots;

  // bf16 -> signed fixed, flush to zero, saturate, round half away from zero
  function automatic logic signed [31:0] bf16_fixed(input logic [15:0] bf,
                                                     input logic [4:0]  fbits);
    logic [7:0]        e;
    logic [30:0]       m;
    logic signed [9:0] sh;
    logic [9:0]        rsh;
    logic [30:0]       mag;
    e   = bf[14:7];
    m   = {23'd0, 1'b1, bf[6:0]};
    sh  = $signed({2'b00, e}) - 10'sd134 + $signed({5'd0, fbits});
    rsh = 10'(-sh);
    if (e >= EXP_FLUSH || e == 8'd0) begin
      mag = '0;
    end else if (sh >= 10'sd24) begin
      mag = SAT_MAG;
    end else if (sh >= 10'sd0) begin
      mag = m << sh[4:0];
    end else if (sh > -10'sd31) begin
      mag = (m + (31'd1 << (rsh[4:0] - 5'd1))) >> rsh[4:0];
    end else begin
      mag = '0;
    end
    return bf[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  logic [4:0]         fb_a;
  logic signed [31:0] conv_a;
  logic signed [31:0] conv_b;
  logic               slot_ok;
  logic               keep;
  entry_t             e_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= ACTIVE_RST;
    end else if (cfg_we) begin
      active_slots <= cfg_data;
    end
  end

  always_comb begin
    case (action)
      ACT_ADD: fb_a = FB_VALUE;
      ACT_MAC: fb_a = FB_WEIGHT;
      default: fb_a = FB_FACTOR;
    endcase
    conv_a  = bf16_fixed(value_a, fb_a);
    conv_b  = bf16_fixed(value_b, FB_FACTOR);
    slot_ok = 32'(slot) < SLOT_COUNT;

    keep     = 1'b0;
    e_n.op   = OP_CLEAR;
    e_n.slot = slot;
    e_n.comp = component;
    e_n.fbits = FB_VALUE;
    e_n.a    = conv_a;
    e_n.b    = 32'sd1;
    case (action)
      ACT_CLEAR: begin
        keep = 1'b1;
      end
      ACT_ADD: begin
        keep   = slot_ok && (component <= COMP_LAST_VALUE);
        e_n.op = OP_ACC;
      end
      ACT_MAC: begin
        keep   = slot_ok && (component inside {[4'd6:4'd8]});
        e_n.op = OP_ACC;
        e_n.b  = conv_b;
      end
      ACT_LOSS: begin
        keep   = 1'b1;
        e_n.op = OP_LOSS;
        e_n.b  = conv_a;
      end
      ACT_READ: begin
        keep = 1'b1;
        if (component == COMP_LOSS) begin
          e_n.op    = OP_READ_LOSS;
          e_n.fbits = FB_LOSS;
        end else if (32'(component) < COMPONENTS && slot_ok &&
                     ({1'b0, slot} < active_slots)) begin
          e_n.op    = OP_READ_SUM;
          e_n.fbits = (component <= COMP_LAST_VALUE) ? FB_VALUE : FB_PRODUCT;
        end else begin
          e_n.op = OP_READ_ZERO;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_ready = push_ready;
  assign push_valid = item_valid && keep;
  assign push_data  = e_n;

endmodule
`default_nettype wire

### sv/bga_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bga_back
// Executes queued operations: row read-modify-write of the accumulator RAM,
// loss update, and fixed-point to float32 read-out with iterative normalize.
// ----------------------------------------------------------------------------
module bga_back #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire bga_pkg::entry_t q_data,
  output      logic            q_pop,
  output      logic            result_valid,
  input  wire logic            result_ready,
  output      logic [31:0]     result_bits
);

  import bga_pkg::*;

  localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_FETCH,
    S_ABS,
    S_NORM,
    S_EMIT
  } state_t;

  state_t                   state;
  entry_t                   cur;
  logic [SLOT_COUNT-1:0]    row_valid;
  logic [SUM_W-1:0]         loss_sum;
  logic signed [SUM_W-1:0]  prod;
  logic [SUM_W-1:0]         acc;
  logic [SUM_W-1:0]         mag;
  logic                     sgn;
  logic [5:0]               msb;
  logic [31:0]              res;

  logic [SLOT_AW-1:0]       raddr;
  logic [SLOT_AW-1:0]       cur_row;
  logic                     ram_we;
  row_t                     rdata;
  row_t                     row_new;
  logic signed [9:0]        ex;

  assign cur_row = SLOT_AW'(cur.slot);
  assign raddr   = (state == S_IDLE) ? SLOT_AW'(q_data.slot) : cur_row;
  assign q_pop   = (state == S_IDLE) && q_valid;
  assign ram_we  = (state == S_UPD) && (cur.op == OP_ACC);

  always_comb begin
    row_new = row_valid[cur_row] ? rdata : '0;
    row_new[cur.comp] = row_new[cur.comp] + prod;
    ex = $signed({4'd0, msb}) + 10'sd127 - $signed({5'd0, cur.fbits});
  end

  bga_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(SLOT_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur_row),
    .wdata(row_new),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      row_valid    <= '0;
      loss_sum     <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != S_EMIT)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur <= q_data;
            case (q_data.op)
              OP_CLEAR: begin
                row_valid <= '0;
                loss_sum  <= '0;
              end
              OP_ACC, OP_LOSS: state <= S_MUL;
              OP_READ_SUM:     state <= S_FETCH;
              OP_READ_LOSS: begin
                acc   <= loss_sum;
                state <= S_ABS;
              end
              default: begin
                res   <= '0;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_MUL: begin
          prod  <= cur.a * cur.b;
          state <= S_UPD;
        end
        S_UPD: begin
          if (cur.op == OP_LOSS) begin
            loss_sum <= loss_sum + prod;
          end else begin
            row_valid[cur_row] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_FETCH: begin
          acc   <= row_valid[cur_row] ? rdata[cur.comp] : '0;
          state <= S_ABS;
        end
        S_ABS: begin
          if (acc == '0) begin
            res   <= '0;
            state <= S_EMIT;
          end else begin
            sgn   <= acc[SUM_W-1];
            mag   <= acc[SUM_W-1] ? (~acc + 64'd1) : acc;
            msb   <= 6'd63;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (mag[63:56] == 8'd0) begin
            mag <= mag << 8;
            msb <= msb - 6'd8;
          end else if (!mag[63]) begin
            mag <= mag << 1;
            msb <= msb - 6'd1;
          end else begin
            if (ex <= 10'sd0) begin
              res <= {sgn, 31'd0};
            end else if (ex >= 10'sd255) begin
              res <= {sgn, F32_INF};
            end else begin
              res <= {sgn, ex[7:0], mag[62:40]};
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            result_bits  <= res;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/bf16_fixed_point_gradient_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bf16_fixed_point_gradient_accumulator
// Bank of 64-bit fixed-point accumulators (9 per slot) plus a loss sum, fed
// with bf16 operands and read back as float32 bits.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake                  | payload
//  item      | in  | item_valid / item_ready    | action slot component value_a value_b
//  result    | out | result_valid / result_ready| result_bits
//  config    | in  | cfg_we (no wait)           | cfg_data -> active_slots
//
//  Clear: done in the back end's idle step. Add / product / square: pop with RAM
//  row read, multiply, row or loss write-back. Read: a zero read goes to emit; a
//  sum or loss read takes its value, then normalizes it (8-bit then 1-bit left
//  shifts of the magnitude). A held result stalls the emit step.
//  A two-entry queue lets the front keep taking transfers while the back works.
//  Reset clears the row valid bits and loss sum at once; no clearing pass.
// ----------------------------------------------------------------------------
module bf16_fixed_point_gradient_accumulator #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        item_valid,
  output      logic        item_ready,
  input  wire logic [2:0]  action,
  input  wire logic [3:0]  slot,
  input  wire logic [3:0]  component,
  input  wire logic [15:0] value_a,
  input  wire logic [15:0] value_b,
  output      logic        result_valid,
  input  wire logic        result_ready,
  output      logic [31:0] result_bits
);

  import bga_pkg::*;

  logic   q_push;
  logic   q_ready;
  entry_t q_in;
  logic   q_valid;
  entry_t q_out;
  logic   q_pop;

  bga_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .action    (action),
    .slot      (slot),
    .component (component),
    .value_a   (value_a),
    .value_b   (value_b),
    .push_valid(q_push),
    .push_data (q_in),
    .push_ready(q_ready)
  );

  bga_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(q_push),
    .push_data (q_in),
    .push_ready(q_ready),
    .pop_valid (q_valid),
    .pop_data  (q_out),
    .pop       (q_pop)
  );

  bga_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_bits (result_bits)
  );

`ifndef ASSERT_OFF
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result_bits)))
    else $error("result dropped or changed while stalled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_read_queued: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && action == ACT_READ) |=> q_valid)
    else $error("read transfer not queued");
`endif

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bf16 gradient accumulator bank. A queue of
// operations (clear, add, product, loss square, read) goes through a bursty
// valid/ready driver. A bit-accurate shadow of the 64-bit sums predicts the
// float32 value of every read, and each returned result is checked in order.
// The active slot count is changed between phases while the bank is idle.
// ----------------------------------------------------------------------------
module tb;
  import bga_pkg::*;

  localparam int SLOT_COUNT       = 16;
  localparam int LIMIT_CYCLES     = 600_000;
  localparam int SETTLE_CYCLES    = 64;
  localparam int RANDOM_PER_PHASE = 150;
  localparam logic [2:0] ACT_LAST = 3'd7;

  typedef struct packed {
    logic        drain;
    logic [2:0]  act;
    logic [3:0]  slot;
    logic [3:0]  comp;
    logic [15:0] va;
    logic [15:0] vb;
  } acc_req_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_mode_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_we       = 1'b0;
  logic [4:0]  cfg_data     = '0;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  logic [2:0]  action       = '0;
  logic [3:0]  slot         = '0;
  logic [3:0]  component    = '0;
  logic [15:0] value_a      = '0;
  logic [15:0] value_b      = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] result_bits;

  bf16_fixed_point_gradient_accumulator #(.SLOT_COUNT(SLOT_COUNT)) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .slot         (slot),
    .component    (component),
    .value_a      (value_a),
    .value_b      (value_b),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_bits  (result_bits)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow of the bank
  logic [63:0] grad_sum [SLOT_COUNT*COMPONENTS];
  logic [63:0] loss_acc;
  logic [4:0]  live_slots;
  logic [31:0] expected_bits [$];
  acc_req_t    pending_reqs [$];

  int          taken_cnt  = 0;
  int          sent_cnt   = 0;
  int          cycle_cnt  = 0;
  int          fails      = 0;
  int          gap_left   = 0;
  int          burst_left = 4;
  int          mode_left  = 0;
  int          stall_phase = 0;
  rx_mode_t    rx_mode    = RX_OPEN;
  acc_req_t    cur_req;
  logic [31:0] want_bits;

  function automatic logic signed [63:0] bf16_to_fixed(input logic [15:0] bf, input int fb);
    int e;
    int sh;
    logic signed [63:0] mag;
    e = int'(bf[14:7]);
    if (e >= EXP_FLUSH || e == 0) return '0;
    mag = {56'd0, 1'b1, bf[6:0]};
    sh = e - 134 + fb;
    if (sh >= 24) mag = {33'd0, SAT_MAG};
    else if (sh >= 0) mag = mag << sh;
    else if (sh > -31) mag = (mag + (64'sd1 << (-sh - 1))) >>> (-sh);
    else mag = '0;
    return bf[15] ? -mag : mag;
  endfunction

  function automatic logic [31:0] sum_to_f32(input logic [63:0] sum, input int fb);
    logic        sgn;
    logic [63:0] mag;
    logic [22:0] frac;
    int          msb;
    int          ex;
    if (sum == '0) return '0;
    sgn = sum[63];
    mag = sgn ? -sum : sum;
    msb = 63;
    while (!mag[msb]) msb--;
    if (msb >= 23) frac = 23'(mag >> (msb - 23));
    else frac = 23'(mag << (23 - msb));
    ex = msb - fb + 127;
    if (ex <= 0) return {sgn, 31'd0};
    if (ex >= 255) return {sgn, F32_INF};
    return {sgn, ex[7:0], frac};
  endfunction

  task automatic predict_transfer(input logic [2:0] act, input logic [3:0] sl,
                                  input logic [3:0] cp, input logic [15:0] va,
                                  input logic [15:0] vb);
    int                 idx;
    logic signed [63:0] q;
    logic [31:0]        bits;
    idx = sl * COMPONENTS + cp;
    case (act)
      ACT_CLEAR: begin
        foreach (grad_sum[i]) grad_sum[i] = '0;
        loss_acc = '0;
      end
      ACT_ADD: begin
        if (cp <= COMP_LAST_VALUE)
          grad_sum[idx] += bf16_to_fixed(va, FB_VALUE);
      end
      ACT_MAC: begin
        if (cp > COMP_LAST_VALUE && cp < COMPONENTS)
          grad_sum[idx] += bf16_to_fixed(va, FB_WEIGHT) * bf16_to_fixed(vb, FB_FACTOR);
      end
      ACT_LOSS: begin
        q = bf16_to_fixed(va, FB_FACTOR);
        loss_acc += q * q;
      end
      ACT_READ: begin
        bits = '0;
        if (cp == COMP_LOSS)
          bits = sum_to_f32(loss_acc, FB_LOSS);
        else if (cp < COMPONENTS && sl < SLOT_COUNT && sl < live_slots)
          bits = sum_to_f32(grad_sum[idx], cp <= COMP_LAST_VALUE ? FB_VALUE : FB_PRODUCT);
        expected_bits.push_back(bits);
      end
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_bf16(input int fb);
    int         r;
    logic       s;
    logic [7:0] e;
    logic [6:0] m;
    r = $urandom_range(0, 99);
    s = 1'($urandom_range(0, 1));
    m = 7'($urandom_range(0, 127));
    if (r < 4) e = '0;
    else if (r < 6) e = 8'hFF;
    else if (r < 8) e = 8'($urandom_range(EXP_FLUSH, 255));
    else if (r < 18) return 16'($urandom_range(0, 65535));
    else e = 8'(134 - fb - 33 + $urandom_range(0, 58));
    if (r < 8 && $urandom_range(0, 1) == 0) m = '0;
    return {s, e, m};
  endfunction

  function automatic acc_req_t random_req();
    acc_req_t req;
    int       r;
    r = $urandom_range(0, 99);
    req.drain = 1'b0;
    req.slot  = 4'($urandom_range(0, 15));
    req.comp  = 4'($urandom_range(0, 15));
    req.va    = 16'($urandom_range(0, 65535));
    req.vb    = 16'($urandom_range(0, 65535));
    if (r < 3) begin
      req.act = ACT_CLEAR;
    end else if (r < 38) begin
      req.act = ACT_ADD;
      if ($urandom_range(0, 9) != 0) req.comp = 4'($urandom_range(0, COMP_LAST_VALUE));
      req.va = pick_bf16(FB_VALUE);
    end else if (r < 63) begin
      req.act = ACT_MAC;
      if ($urandom_range(0, 9) != 0)
        req.comp = 4'($urandom_range(COMP_LAST_VALUE + 1, COMPONENTS - 1));
      req.va = pick_bf16(FB_WEIGHT);
      req.vb = pick_bf16(FB_FACTOR);
    end else if (r < 72) begin
      req.act = ACT_LOSS;
      req.va = pick_bf16(FB_FACTOR);
    end else if (r < 98) begin
      req.act = ACT_READ;
      if ($urandom_range(0, 11) != 0) req.comp = 4'($urandom_range(0, COMP_LOSS));
    end else begin
      req.act = 3'($urandom_range(ACT_READ + 1, ACT_LAST));
    end
    return req;
  endfunction

  task automatic push_req(input logic [2:0] act, input logic [3:0] sl,
                          input logic [3:0] cp, input logic [15:0] va,
                          input logic [15:0] vb);
    pending_reqs.push_back({1'b0, act, sl, cp, va, vb});
  endtask

  task automatic drain_bank();
    while (pending_reqs.size() != 0 || taken_cnt != sent_cnt || expected_bits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active_slots(input logic [4:0] n);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= n;
    @(negedge clk);
    cfg_we   <= 1'b0;
    live_slots = n;
  endtask

  // sender: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || taken_cnt == sent_cnt) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain && expected_bits.size() != 0)) begin
        cur_req = pending_reqs.pop_front();
        action     <= cur_req.act;
        slot       <= cur_req.slot;
        component  <= cur_req.comp;
        value_a    <= cur_req.va;
        value_b    <= cur_req.vb;
        item_valid <= 1'b1;
        sent_cnt++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 8);
          case ($urandom_range(0, 19))
            0:       gap_left = $urandom_range(20, 40);
            1, 2, 3: gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(0, 3);
          endcase
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes every so often
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    stall_phase++;
    case (rx_mode)
      RX_OPEN:   result_ready <= 1'b1;
      RX_COIN:   result_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
      default:   result_ready <= (stall_phase % 7) > 2;
    endcase
  end

  // monitor and checker
  always @(posedge clk) begin
    cycle_cnt++;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_bits.size() == 0) begin
          $error("result_bits: no result expected, actual %h", result_bits);
          fails++;
        end else begin
          want_bits = expected_bits.pop_front();
          if (result_bits !== want_bits) begin
            $error("result_bits: expected %h, actual %h", want_bits, result_bits);
            fails++;
          end
        end
      end
      if (item_valid && item_ready) begin
        taken_cnt++;
        predict_transfer(action, slot, component, value_a, value_b);
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk);
    $display("bf16_fixed_point_gradient_accumulator verification failed");
    $finish;
  end

  initial begin
    logic [4:0] phase_slots [5];
    acc_req_t   req;
    phase_slots = '{5'd0, ACTIVE_RST, 5'd1, 5'd0, ACTIVE_RST};
    phase_slots[3] = 5'($urandom_range(2, 15));
    foreach (grad_sum[i]) grad_sum[i] = '0;
    loss_acc   = '0;
    live_slots = ACTIVE_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: flushes, saturation, rounding, ignored targets, bad actions
    push_req(ACT_READ,  4'd0,  4'd0,  16'h0000, 16'h0000);
    push_req(ACT_ADD,   4'd0,  4'd0,  16'h3F80, 16'h0000);
    push_req(ACT_ADD,   4'd15, 4'd5,  16'hC700, 16'hFFFF);
    push_req(ACT_ADD,   4'd0,  4'd1,  16'h0001, 16'h0000);
    push_req(ACT_ADD,   4'd0,  4'd1,  16'h7F80, 16'h0000);
    push_req(ACT_ADD,   4'd0,  4'd1,  16'hFFC1, 16'h0000);
    push_req(ACT_ADD,   4'd0,  4'd1,  16'h7180, 16'h0000);
    push_req(ACT_ADD,   4'd0,  4'd2,  16'h3A81, 16'h0000);
    push_req(ACT_ADD,   4'd0,  4'd2,  16'h0F80, 16'h0000);
    push_req(ACT_ADD,   4'd3,  4'd7,  16'h3F80, 16'h0000);
    push_req(ACT_MAC,   4'd1,  4'd6,  16'h3F80, 16'hBF80);
    push_req(ACT_MAC,   4'd15, 4'd8,  16'h7100, 16'h7100);
    push_req(ACT_MAC,   4'd2,  4'd5,  16'h3F80, 16'h3F80);
    push_req(ACT_LOSS,  4'd9,  4'd3,  16'h4000, 16'h0000);
    push_req(ACT_LOSS,  4'd0,  4'd0,  16'hF100, 16'h0000);
    push_req(3'(ACT_READ + 1), 4'd0, 4'd0, 16'h3F80, 16'h3F80);
    push_req(ACT_LAST,  4'd15, 4'd15, 16'hFFFF, 16'hFFFF);
    push_req(ACT_READ,  4'd0,  4'd0,  16'h0000, 16'h0000);
    push_req(ACT_READ,  4'd15, 4'd5,  16'h0000, 16'h0000);
    push_req(ACT_READ,  4'd0,  4'd2,  16'h0000, 16'h0000);
    push_req(ACT_READ,  4'd1,  4'd6,  16'h0000, 16'h0000);
    push_req(ACT_READ,  4'd15, 4'd8,  16'h0000, 16'h0000);
    push_req(ACT_READ,  4'd7,  COMP_LOSS, 16'h0000, 16'h0000);
    push_req(ACT_READ,  4'd0,  4'd15, 16'h0000, 16'h0000);
    push_req(ACT_CLEAR, 4'd0,  4'd0,  16'h0000, 16'h0000);
    push_req(ACT_READ,  4'd15, 4'd5,  16'h0000, 16'h0000);
    drain_bank();

    foreach (phase_slots[p]) begin
      set_active_slots(phase_slots[p]);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        req = random_req();
        req.drain = (i == RANDOM_PER_PHASE / 2) || ($urandom_range(0, 79) == 0);
        pending_reqs.push_back(req);
      end
      drain_bank();
    end

    if (fails == 0)
      $display("bf16_fixed_point_gradient_accumulator verification clean");
    else
      $display("bf16_fixed_point_gradient_accumulator verification failed");
    $finish;
  end

endmodule

### sim.f
sv/bga_pkg.sv
sv/bga_ram.sv
sv/bga_queue.sv
sv/bga_front.sv
sv/bga_back.sv
sv/bf16_fixed_point_gradient_accumulator.sv
bench/tb.sv
